// File: design/fhpt_pkg.sv
package fhpt_pkg;

    localparam int PID_W  = 31;
    localparam int CALL_W = 32;
    localparam int SEEN_W = 7;

    // Item kinds.
    localparam logic KIND_CHECK  = 1'b0;
    localparam logic KIND_FORGET = 1'b1;

    // Tracked call numbers, one seen bit each.
    localparam logic [CALL_W-1:0] CALL_0 = 32'd1031;
    localparam logic [CALL_W-1:0] CALL_1 = 32'd1032;
    localparam logic [CALL_W-1:0] CALL_2 = 32'd1033;
    localparam logic [CALL_W-1:0] CALL_3 = 32'd1034;
    localparam logic [CALL_W-1:0] CALL_4 = 32'd1038;
    localparam logic [CALL_W-1:0] CALL_5 = 32'd1039;
    localparam logic [CALL_W-1:0] CALL_6 = 32'd1040;

    // Request held while the cells look it up.
    typedef struct packed {
        logic              kind;
        logic [PID_W-1:0]  pid;
        logic [SEEN_W-1:0] mask;
    } req_t;

    // Running flags handed from one cell to the next.
    typedef struct packed {
        logic hit;
        logic bit_seen;
        logic empty;
    } chain_t;

    // One-hot seen mask of a call number, zero when it is not tracked.
    function automatic logic [SEEN_W-1:0] call_mask(input logic [CALL_W-1:0] num);
        logic [SEEN_W-1:0] m;
        m = '0;
        unique case (num)
            CALL_0:  m = 7'b0000001;
            CALL_1:  m = 7'b0000010;
            CALL_2:  m = 7'b0000100;
            CALL_3:  m = 7'b0001000;
            CALL_4:  m = 7'b0010000;
            CALL_5:  m = 7'b0100000;
            CALL_6:  m = 7'b1000000;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// File: design/first_hit_per_process_tracker.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+-----------------------------------
// input    | in_valid / in_stall | kind, process_id, call_number
// output   | out_valid/out_stall | audit, tracked
//
// For each item the request is registered first; then, in the lookup state,
// every cell compares its process id and the first-empty and hit flags
// ripple down the row of cells, after which the slots update and the result
// is registered. Reset clears every slot and the victim pointer at once.
// A new item is taken once the previous result has left or leaves in the
// same cycle; a stalled output holds its result and blocks further input.
module first_hit_per_process_tracker
    import fhpt_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              kind,
    input  logic [PID_W-1:0]  process_id,
    input  logic [CALL_W-1:0] call_number,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              audit,
    output logic              tracked
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    logic             state_reg;
    logic             state_next;
    req_t             req_reg;
    logic [IDX_W-1:0] victim_reg;
    logic [IDX_W-1:0] victim_next;
    logic             out_valid_reg;
    logic             audit_reg;
    logic             tracked_reg;
    logic             in_xfer;
    logic             look;
    logic             hit_any;
    logic             any_empty;
    logic             is_check;
    chain_t           links [SLOTS+1];

    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_xfer  = in_valid && !in_stall;
    assign look     = (state_reg == ST_LOOK);

    // Row of slot cells.
    assign links[0] = '0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        fhpt_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .look      (look),
            .req       (req_reg),
            .victim    (victim_reg),
            .hit_any   (hit_any),
            .any_empty (any_empty),
            .chain_in  (links[i]),
            .chain_out (links[i+1])
        );
    end

    assign hit_any   = links[SLOTS].hit;
    assign any_empty = links[SLOTS].empty;
    assign is_check  = (req_reg.kind == KIND_CHECK) && (req_reg.mask != '0);

    // Sequencer and victim pointer.
    always_comb
    begin
        state_next  = state_reg;
        victim_next = victim_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_IDLE;
                if (is_check && !hit_any && !any_empty)
                begin
                    victim_next = (victim_reg == LAST_IDX) ? '0 : victim_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            victim_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            victim_reg <= victim_next;
            if (look)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture on an input transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg.kind <= kind;
            req_reg.pid  <= process_id;
            req_reg.mask <= call_mask(call_number);
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (look)
        begin
            if (req_reg.kind == KIND_FORGET)
            begin
                audit_reg   <= 1'b0;
                tracked_reg <= 1'b0;
            end
            else if (req_reg.mask == '0)
            begin
                audit_reg   <= 1'b1;
                tracked_reg <= 1'b0;
            end
            else
            begin
                audit_reg   <= hit_any ? !links[SLOTS].bit_seen : 1'b1;
                tracked_reg <= 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign audit     = audit_reg;
    assign tracked   = tracked_reg;

endmodule

// File: design/fhpt_cell.sv
module fhpt_cell
    import fhpt_pkg::*;
#(
    parameter int IDX_W = 4,
    parameter int INDEX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             look,
    input  req_t             req,
    input  logic [IDX_W-1:0] victim,
    input  logic             hit_any,
    input  logic             any_empty,
    input  chain_t           chain_in,
    output chain_t           chain_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic              valid_reg;
    logic              valid_next;
    logic [PID_W-1:0]  pid_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;
    logic              match;
    logic              take;
    logic              is_check;

    // Compare against the request and extend the running flags.
    assign match    = valid_reg && (pid_reg == req.pid);
    assign is_check = (req.kind == KIND_CHECK) && (req.mask != '0);

    assign chain_out.hit      = chain_in.hit | match;
    assign chain_out.bit_seen = chain_in.bit_seen | (match && ((seen_reg & req.mask) != '0));
    assign chain_out.empty    = chain_in.empty | !valid_reg;

    // This slot is installed on a miss if it is the first empty one or, when no slot is empty, the victim.
    assign take = is_check && !hit_any &&
                  ((!valid_reg && !chain_in.empty) || (!any_empty && (victim == MY_IDX)));

    // Next state of the slot flags.
    always_comb
    begin
        valid_next = valid_reg;
        seen_next  = seen_reg;
        if (look)
        begin
            if ((req.kind == KIND_FORGET) && match)
            begin
                valid_next = 1'b0;
                seen_next  = '0;
            end
            else if (is_check && match)
            begin
                seen_next = seen_reg | req.mask;
            end
            else if (take)
            begin
                valid_next = 1'b1;
                seen_next  = req.mask;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            seen_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            seen_reg  <= seen_next;
        end
    end

    // The process id is only compared while the slot is valid.
    always_ff @(posedge clk)
    begin
        if (look && take)
        begin
            pid_reg <= req.pid;
        end
    end

endmodule

// File: design/fhpt_checker.sv
module fhpt_checker
    import fhpt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              kind,
    input logic              out_valid,
    input logic              out_stall,
    input logic              audit,
    input logic              tracked
);

    logic in_xfer;

    assign in_xfer = in_valid && !in_stall;

    // The block is busy in the cycle after a transfer in.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_stall)
        else $error("input not stalled while an item is looked up");

    // A result shows up after every input transfer, once the request is registered and looked up.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> ##1 out_valid)
        else $error("result missing after an input transfer");

    // Forget items report neither audit nor tracked.
    a_forget_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (kind == KIND_FORGET)) |=> ##1 (!audit && !tracked))
        else $error("forget item gave a nonzero result");

    // Check items always report audit or tracked.
    a_check_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (kind == KIND_CHECK)) |=> ##1 (audit || tracked))
        else $error("check item gave an empty result");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(audit) && $stable(tracked)))
        else $error("stalled result changed");

endmodule

bind first_hit_per_process_tracker fhpt_checker u_fhpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .audit     (audit),
    .tracked   (tracked)
);
